FILE: rtl/core/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master control sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   // Control machine states, numbered as the state code reports them
   typedef enum logic [4:0] {
      ST_OFF               = 5'd0,
      ST_IDLE              = 5'd1,
      ST_CLK_INIT          = 5'd2,
      ST_START_GEN         = 5'd3,
      ST_START_DONE        = 5'd4,
      ST_RD_SR1_WAIT_DR    = 5'd5,
      ST_ADDR_LOAD         = 5'd6,
      ST_ADDR_SHIFT        = 5'd7,
      ST_ADDR_FIN          = 5'd8,
      ST_RD_SR1_WAIT_SR2   = 5'd9,
      ST_DIR_SELECT        = 5'd10,
      ST_LOAD_SHIFT        = 5'd11,
      ST_LOAD_SHIFT_2      = 5'd12,
      ST_TX_DATA_1         = 5'd13,
      ST_TX_DATA_2         = 5'd14,
      ST_TX_DONE           = 5'd15,
      ST_RECV_DATA_1       = 5'd16,
      ST_RECV_DATA_2       = 5'd17,
      ST_CHECK_DR          = 5'd18,
      ST_CHECK_ACK_NACK    = 5'd19,
      ST_SEND_ACK          = 5'd20,
      ST_SEND_NACK         = 5'd21,
      ST_READ_FIN          = 5'd22,
      ST_STOP_GEN          = 5'd23,
      ST_STOP_DONE         = 5'd24,
      ST_ACK_ERROR         = 5'd25,
      ST_ERROR             = 5'd26,
      ST_DE_INIT           = 5'd27
   } state_type;

   // CPU register access codes
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_RD_SR1 = 3'd1;
   localparam logic [2:0] OP_RD_SR2 = 3'd2;
   localparam logic [2:0] OP_WR_DR  = 3'd3;
   localparam logic [2:0] OP_RD_DR  = 3'd4;

   // SR1 flags
   localparam logic [5:0] F_START = 6'h01;
   localparam logic [5:0] F_ADDR  = 6'h02;
   localparam logic [5:0] F_TXE   = 6'h04;
   localparam logic [5:0] F_BTF   = 6'h08;
   localparam logic [5:0] F_RXNE  = 6'h10;
   localparam logic [5:0] F_AF    = 6'h20;

   // SR2 flags
   localparam logic [2:0] M_MSL  = 3'h1;
   localparam logic [2:0] M_BUSY = 3'h2;
   localparam logic [2:0] M_TRA  = 3'h4;

   // Clear pulses
   localparam logic [2:0] CLR_REGS  = 3'h1;
   localparam logic [2:0] CLR_START = 3'h2;
   localparam logic [2:0] CLR_STOP  = 3'h4;

   // Shift engine commands
   localparam logic [1:0] SHIFT_NONE = 2'd0;
   localparam logic [1:0] SHIFT_TX   = 2'd1;
   localparam logic [1:0] SHIFT_RX   = 2'd2;

   // Acknowledge commands
   localparam logic [1:0] ACK_NONE = 2'd0;
   localparam logic [1:0] ACK_SEND = 2'd1;
   localparam logic [1:0] ACK_NACK = 2'd2;

   // Slave response bits
   localparam int unsigned RESP_ACK_BIT  = 0;
   localparam int unsigned RESP_NACK_BIT = 1;

   // One request: last field in the lowest bits
   typedef struct packed {
      logic [1:0] ack_response;
      logic       byte_loaded;
      logic       shift_loaded;
      logic       sending_data;
      logic       condition_done;
      logic       scl_ready;
      logic       rw_bit;
      logic [2:0] opcode;
      logic       ack_enable;
      logic       stop_req;
      logic       start_req;
      logic       enable;
   } item_type;

   // One result: last field in the lowest bits
   typedef struct packed {
      logic [1:0] ack_cmd;
      logic [1:0] shift_cmd;
      logic       gen_stop;
      logic       gen_start;
      logic       clk_init;
      logic       clock_stretch;
      logic       scl_on;
      logic [2:0] clear_pulses;
      logic [2:0] sr2_flags;
      logic [5:0] sr1_flags;
      logic [4:0] state_code;
   } result_type;

   localparam int unsigned ITEM_W   = $bits(item_type);
   localparam int unsigned RESULT_W = $bits(result_type);
   localparam int unsigned REQ_W    = ((ITEM_W + 7) / 8) * 8;
   localparam int unsigned RSP_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

FILE: rtl/core/i2cms_fsm.sv
// ----------------------------------------------------------------------------
// i2cms_fsm
// Control state register with next-state and output decode for one request.
// ----------------------------------------------------------------------------
module i2cms_fsm
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,      // request in the input register moves on
   input  item_type   item,
   output result_type result
);

   state_type state_ff;
   state_type state_in;

   logic rd_sr1, rd_sr2, wr_dr, rd_dr;
   logic ack, nack, stop_only;
   logic [2:0] tra_rw;
   logic [2:0] mb;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_OFF;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rd_sr1    = (item.opcode == OP_RD_SR1);
      rd_sr2    = (item.opcode == OP_RD_SR2);
      wr_dr     = (item.opcode == OP_WR_DR);
      rd_dr     = (item.opcode == OP_RD_DR);
      ack       = item.ack_response[RESP_ACK_BIT];
      nack      = item.ack_response[RESP_NACK_BIT];
      stop_only = item.stop_req & ~item.start_req;
      tra_rw    = item.rw_bit ? M_TRA : 3'h0;
      mb        = M_MSL | M_BUSY;

      state_in = state_ff;
      result   = '0;
      result.state_code = state_ff;

      unique case (state_ff)
         ST_OFF: begin
            if (item.enable) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (item.start_req && !item.stop_req) state_in = ST_CLK_INIT;
         end
         ST_CLK_INIT: begin
            result.sr2_flags = mb;
            result.clk_init  = 1'b1;
            if (item.scl_ready) state_in = ST_START_GEN;
         end
         ST_START_GEN: begin
            result.sr2_flags = mb;
            result.scl_on    = 1'b1;
            result.gen_start = 1'b1;
            if (item.condition_done) state_in = ST_START_DONE;
         end
         ST_START_DONE: begin
            result.scl_on        = 1'b1;
            result.sr1_flags     = F_START;
            result.sr2_flags     = mb;
            result.clock_stretch = 1'b1;
            if (rd_sr1) state_in = ST_RD_SR1_WAIT_DR;
            if (item.stop_req) state_in = ST_STOP_GEN;
         end
         ST_RD_SR1_WAIT_DR: begin
            result.scl_on        = 1'b1;
            result.sr1_flags     = F_START;
            result.sr2_flags     = mb;
            result.clock_stretch = 1'b1;
            if (wr_dr) state_in = ST_ADDR_LOAD;
         end
         ST_ADDR_LOAD: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.clear_pulses  = CLR_START;
            result.sr2_flags     = mb | tra_rw;
            result.shift_cmd     = SHIFT_TX;
            if (item.sending_data) state_in = ST_ADDR_SHIFT;
         end
         ST_ADDR_SHIFT: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb | tra_rw;
            if (ack) state_in = ST_ADDR_FIN;
            else if (nack) state_in = ST_ACK_ERROR;
         end
         ST_ADDR_FIN: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.sr1_flags     = F_ADDR;
            result.sr2_flags     = mb | tra_rw;
            if (rd_sr1) state_in = ST_RD_SR1_WAIT_SR2;
         end
         ST_RD_SR1_WAIT_SR2: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.sr1_flags     = F_ADDR;
            result.sr2_flags     = mb | tra_rw;
            if (rd_sr2) state_in = ST_DIR_SELECT;
         end
         ST_DIR_SELECT: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.sr2_flags     = mb | tra_rw;
            if (item.rw_bit) state_in = ST_RECV_DATA_1;
            else if (wr_dr) state_in = ST_LOAD_SHIFT;
            else if (stop_only) state_in = ST_STOP_GEN;
         end
         ST_LOAD_SHIFT: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.sr2_flags     = mb;
            result.shift_cmd     = SHIFT_TX;
            if (item.shift_loaded) state_in = ST_LOAD_SHIFT_2;
         end
         ST_LOAD_SHIFT_2: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.sr2_flags     = mb;
            result.sr1_flags     = F_TXE;
            if (item.sending_data) state_in = ST_TX_DATA_1;
         end
         ST_TX_DATA_1: begin
            result.scl_on    = 1'b1;
            result.sr1_flags = F_TXE;
            result.sr2_flags = mb;
            if (wr_dr) state_in = ST_TX_DATA_2;
            else if (ack) state_in = ST_TX_DONE;
            else if (nack) state_in = ST_ACK_ERROR;
         end
         ST_TX_DATA_2: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb;
            if (ack) state_in = ST_LOAD_SHIFT;
            else if (nack) state_in = ST_ACK_ERROR;
         end
         ST_TX_DONE: begin
            result.clock_stretch = 1'b1;
            result.scl_on        = 1'b1;
            result.sr1_flags     = F_BTF | F_TXE;
            result.sr2_flags     = mb;
            if (wr_dr) state_in = ST_LOAD_SHIFT;
            else if (stop_only) state_in = ST_STOP_GEN;
         end
         ST_RECV_DATA_1: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb | M_TRA;
            result.shift_cmd = SHIFT_RX;
            if (item.shift_loaded) state_in = ST_CHECK_ACK_NACK;
         end
         ST_RECV_DATA_2: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb | M_TRA;
            result.sr1_flags = F_RXNE;
            result.shift_cmd = SHIFT_RX;
            if (rd_dr) state_in = ST_RECV_DATA_1;
            if (item.shift_loaded) state_in = ST_CHECK_DR;
         end
         ST_CHECK_DR: begin
            result.scl_on        = 1'b1;
            result.sr2_flags     = mb | M_TRA;
            result.sr1_flags     = F_RXNE;
            result.clock_stretch = 1'b1;
            if (rd_dr) state_in = ST_CHECK_ACK_NACK;
         end
         ST_CHECK_ACK_NACK: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb | M_TRA;
            state_in = item.ack_enable ? ST_SEND_ACK : ST_SEND_NACK;
         end
         ST_SEND_ACK: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb | M_TRA;
            result.ack_cmd   = ACK_SEND;
            if (item.byte_loaded) state_in = ST_RECV_DATA_2;
         end
         ST_SEND_NACK: begin
            result.scl_on    = 1'b1;
            result.sr2_flags = mb | M_TRA;
            result.ack_cmd   = ACK_NACK;
            if (item.byte_loaded) state_in = ST_READ_FIN;
         end
         ST_READ_FIN: begin
            result.scl_on        = 1'b1;
            result.sr2_flags     = mb | M_TRA;
            result.clock_stretch = 1'b1;
            result.sr1_flags     = F_RXNE;
            if (stop_only) state_in = ST_STOP_GEN;
         end
         ST_STOP_GEN: begin
            result.scl_on   = 1'b1;
            result.gen_stop = 1'b1;
            if (item.condition_done) state_in = ST_STOP_DONE;
         end
         ST_STOP_DONE: begin
            result.clear_pulses = CLR_STOP;
            state_in = ST_IDLE;
         end
         ST_ACK_ERROR: begin
            result.scl_on    = 1'b1;
            result.sr1_flags = F_AF;
            if (stop_only) state_in = ST_STOP_GEN;
         end
         ST_ERROR: begin
            state_in = ST_ERROR;
         end
         ST_DE_INIT: begin
            result.clear_pulses = CLR_REGS;
            state_in = ST_OFF;
         end
         default: begin
            // unused codes fall into the trap
            state_in = ST_ERROR;
         end
      endcase

      if (!item.enable && state_ff != ST_OFF && state_ff != ST_DE_INIT) begin
         state_in = ST_DE_INIT;
      end
   end

endmodule

FILE: rtl/core/i2c_master_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_sequencer_unit
// Control sequencer of an I2C master: one request per sampled cycle in,
// one result with status flags and line/shift commands out.
// ----------------------------------------------------------------------------
// Path:    a request goes from the input register through the state machine
//          into the result register, which drives rsp_tvalid.
// Throughput: one request per clock while the result is not stalled; the
//          state update is a single pass of decode logic, so back-to-back
//          requests chain through the state. Input stalls only while both
//          registers hold and rsp_tready is low.
// Reset: synchronous, active high; empties both registers and puts the
//          control machine in OFF.
// ----------------------------------------------------------------------------
module i2c_master_sequencer_unit
   import i2cms_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   // [0] enable, [1] start_req, [2] stop_req, [3] ack_enable, [6:4] opcode,
   // [7] rw_bit, [8] scl_ready, [9] condition_done, [10] sending_data,
   // [11] shift_loaded, [12] byte_loaded, [14:13] ack_response, [15] unused
   input  logic [REQ_W-1:0] req_tdata,
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [4:0] state_code, [10:5] sr1_flags, [13:11] sr2_flags,
   // [16:14] clear_pulses, [17] scl_on, [18] clock_stretch,
   // [19] clk_init, [20] gen_start, [21] gen_stop, [23:22] shift_cmd,
   // [25:24] ack_cmd, [31:26] zero
   output logic [RSP_W-1:0] rsp_tdata
);

   // input register
   logic       in_valid_ff;
   item_type   in_item_ff;

   // result register
   logic       out_valid_ff;
   result_type out_data_ff;

   logic       out_free;   // result register can take a new result
   logic       step;       // request in the input register is decoded now
   result_type fsm_result;

   assign out_free   = ~out_valid_ff | rsp_tready;
   assign step       = in_valid_ff & out_free;
   // input register frees up whenever its request moves on
   assign req_tready = ~in_valid_ff | out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= item_type'(req_tdata[ITEM_W-1:0]);
      end
   end

   // State register and decode; state advances only when the result is kept
   i2cms_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .result (fsm_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= fsm_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_W - RESULT_W){1'b0}}, out_data_ff};

endmodule

FILE: rtl/core/i2cms_checker.sv
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cms_checker
   import i2cms_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   result_type rsp;
   assign rsp = result_type'(rsp_tdata[RESULT_W-1:0]);

   // an offered request waits unchanged until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("request changed while waiting");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // with no result waiting the block always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty result register");

   // OFF drives nothing; DE_INIT only clears registers
   a_quiet_states: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.state_code == ST_OFF || rsp.state_code == ST_DE_INIT)
      |-> rsp.sr1_flags == '0 && rsp.sr2_flags == '0 && !rsp.scl_on
          && !rsp.gen_start && !rsp.gen_stop && rsp.shift_cmd == SHIFT_NONE
          && (rsp.clear_pulses == '0 || rsp.clear_pulses == CLR_REGS))
      else $error("unexpected command in OFF or DE_INIT");

endmodule

bind i2c_master_sequencer_unit i2cms_checker u_i2cms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
